>>> hw/rtl/cibcp_pkg.sv
// Shared types and constants for the CPU idle/busy cycle profiler.
// No dependencies; imported by cibcp_share and cpu_idle_busy_cycle_profiler.
package cibcp_pkg;

    localparam int unsigned STAMP_W = 64;
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned PPM_W   = 20;
    // part * 1e6 fits in 64 + 20 bits
    localparam int unsigned PROD_W  = STAMP_W + PPM_W;
    localparam int unsigned HALF_W  = STAMP_W / 2;

    localparam logic [PPM_W-1:0] PPM_SCALE = PPM_W'(1000000);

    // event codes
    localparam logic [1:0] REQ_SWITCH_IN  = 2'd0;
    localparam logic [1:0] REQ_SWITCH_OUT = 2'd1;
    localparam logic [1:0] REQ_CLEAR      = 2'd2;
    localparam logic [1:0] REQ_SNAPSHOT   = 2'd3;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [STAMP_W-1:0] timestamp;
        logic               task_present;
        logic               task_is_idle;
    } t_req;

    typedef struct packed {
        logic [STAMP_W-1:0] wall_count;
        logic [STAMP_W-1:0] idle_count;
        logic [STAMP_W-1:0] busy_cycles;
        logic [COUNT_W-1:0] switch_count;
        logic [PPM_W-1:0]   idle_ppm;
        logic [PPM_W-1:0]   busy_ppm;
    } t_rsp;

endpackage

>>> hw/rtl/cibcp_share.sv
// Share unit: floor(part * 1e6 / whole), saturated at 1e6, 0 for whole == 0.
// One 32x20 multiplier for the low half and then the high half, then a restoring divider, one bit a cycle.
// Depends on cibcp_pkg.
module cibcp_share (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [cibcp_pkg::STAMP_W-1:0]   i_part,
    input  logic [cibcp_pkg::STAMP_W-1:0]   i_whole,
    output logic                            o_done,
    output logic [cibcp_pkg::PPM_W-1:0]     o_ppm
);
    import cibcp_pkg::*;

    localparam int unsigned CNT_W = $clog2(PROD_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(PROD_W - 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MLO  = 5'b00010,
        S_MHI  = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    logic [STAMP_W-1:0]   r_part;
    logic [STAMP_W-1:0]   r_whole;
    logic [PROD_W-1:0]    r_dvd;
    logic [STAMP_W-1:0]   r_rem;
    logic [PPM_W:0]       r_q;
    logic [CNT_W-1:0]     r_cnt;

    logic [HALF_W-1:0]       w_mul_a;
    logic [HALF_W+PPM_W-1:0] w_prod;
    logic [STAMP_W:0]        w_rem_sh;
    logic [STAMP_W:0]        w_diff;
    logic                    w_ge;
    logic [PPM_W:0]          w_q_sh;

    // shared multiplier: low half first, then high half
    assign w_mul_a = (r_state == S_MLO) ? r_part[HALF_W-1:0] : r_part[STAMP_W-1:HALF_W];
    assign w_prod  = w_mul_a * PPM_SCALE;

    assign w_rem_sh = {r_rem, r_dvd[PROD_W-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_whole};
    assign w_ge     = (w_rem_sh >= {1'b0, r_whole});
    // quotient stops growing once past full scale
    assign w_q_sh   = (r_q <= {1'b0, PPM_SCALE}) ? {r_q[PPM_W-1:0], 1'b0} : r_q;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = (i_whole == '0) ? S_DONE : S_MLO;
                end
            end
            S_MLO:  n_state = S_MHI;
            S_MHI:  n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == LAST_STEP) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_part  <= i_part;
                r_whole <= i_whole;
                r_q     <= '0;
                r_rem   <= '0;
                r_cnt   <= '0;
            end
            S_MLO: begin
                r_dvd <= PROD_W'(w_prod);
            end
            S_MHI: begin
                r_dvd <= r_dvd + {w_prod, {HALF_W{1'b0}}};
            end
            S_DIV: begin
                r_rem <= w_ge ? w_diff[STAMP_W-1:0] : w_rem_sh[STAMP_W-1:0];
                r_q   <= w_q_sh | {{PPM_W{1'b0}}, w_ge};
                r_dvd <= {r_dvd[PROD_W-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_done = (r_state == S_DONE);
    assign o_ppm  = (r_q > {1'b0, PPM_SCALE}) ? PPM_SCALE : r_q[PPM_W-1:0];

endmodule

>>> hw/rtl/cpu_idle_busy_cycle_profiler.sv
// CPU idle/busy cycle profiler: top level, event sequencer and totals.
// Depends on cibcp_pkg and cibcp_share.
//
//  channel | signals                          | direction | carries
//  --------+----------------------------------+-----------+------------------------------
//  req     | i_req_valid, o_req_ready, i_req  | in        | scheduler event (t_req)
//  rsp     | o_rsp_valid, i_rsp_ready, o_rsp  | out       | snapshot totals + ppm (t_rsp)
//
// Switch-in and clear take effect in the accept cycle; the next transaction
// may follow in the next cycle. Switch-out runs a difference step, then an add step.
// Snapshot runs the same difference and add steps, then two passes of the share
// unit (multiply low and high halves, 84 divide steps, handoff) for idle and busy shares.
// Synchronous active-low reset clears all totals, the stamp and the active task.
// A finished result sits in the output register; a new event is taken meanwhile,
// and only a following snapshot waits there for the response to drain.
module cpu_idle_busy_cycle_profiler (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  cibcp_pkg::t_req   i_req,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    output cibcp_pkg::t_rsp   o_rsp
);
    import cibcp_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b00000001,
        ST_CHARGE = 8'b00000010,
        ST_ACCUM  = 8'b00000100,
        ST_IGO    = 8'b00001000,
        ST_IWAIT  = 8'b00010000,
        ST_BGO    = 8'b00100000,
        ST_BWAIT  = 8'b01000000,
        ST_OUT    = 8'b10000000
    } t_state;

    t_state              r_state, n_state;
    t_req                r_req;
    logic                r_active_valid;
    logic                r_active_idle;
    logic [STAMP_W-1:0]  r_start;
    logic [STAMP_W-1:0]  r_wall;
    logic [STAMP_W-1:0]  r_idle;
    logic [STAMP_W-1:0]  r_busy;
    logic [COUNT_W-1:0]  r_switches;
    logic [STAMP_W-1:0]  r_delta;
    logic                r_do_charge;
    logic [PPM_W-1:0]    r_idle_ppm;
    logic [PPM_W-1:0]    r_busy_ppm;
    logic                r_rsp_valid;
    t_rsp                r_rsp;

    logic                w_req_acc;
    logic                w_out_free;
    logic                w_sh_start;
    logic [STAMP_W-1:0]  w_sh_part;
    logic                w_sh_done;
    logic [PPM_W-1:0]    w_sh_ppm;

    assign o_req_ready = (r_state == ST_IDLE);
    assign w_req_acc   = i_req_valid && o_req_ready;
    assign w_out_free  = !r_rsp_valid || i_rsp_ready;

    // one share unit, used for the idle share and then the busy share
    assign w_sh_start = (r_state == ST_IGO) || (r_state == ST_BGO);
    assign w_sh_part  = (r_state == ST_IGO) ? r_idle : r_busy;

    cibcp_share u_share (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sh_start),
        .i_part  (w_sh_part),
        .i_whole (r_wall),
        .o_done  (w_sh_done),
        .o_ppm   (w_sh_ppm)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_req_acc && ((i_req.req_type == REQ_SWITCH_OUT) ||
                                  (i_req.req_type == REQ_SNAPSHOT))) begin
                    n_state = ST_CHARGE;
                end
            end
            ST_CHARGE: n_state = ST_ACCUM;
            ST_ACCUM: begin
                n_state = (r_req.req_type == REQ_SNAPSHOT) ? ST_IGO : ST_IDLE;
            end
            ST_IGO:    n_state = ST_IWAIT;
            ST_IWAIT: begin
                if (w_sh_done) begin
                    n_state = ST_BGO;
                end
            end
            ST_BGO:    n_state = ST_BWAIT;
            ST_BWAIT: begin
                if (w_sh_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_active_valid <= 1'b0;
            r_active_idle  <= 1'b0;
            r_start        <= '0;
            r_wall         <= '0;
            r_idle         <= '0;
            r_busy         <= '0;
            r_switches     <= '0;
            r_rsp_valid    <= 1'b0;
        end else begin
            r_state <= n_state;

            // load wins over drain: the register refills as it empties
            if ((r_state == ST_OUT) && w_out_free) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (w_req_acc) begin
                        case (i_req.req_type)
                            REQ_SWITCH_IN: begin
                                r_active_valid <= i_req.task_present;
                                r_active_idle  <= i_req.task_is_idle;
                                r_start        <= i_req.timestamp;
                            end
                            REQ_CLEAR: begin
                                r_wall     <= '0;
                                r_idle     <= '0;
                                r_busy     <= '0;
                                r_switches <= '0;
                                r_start    <= i_req.timestamp;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_ACCUM: begin
                    if (r_do_charge) begin
                        r_wall  <= r_wall + r_delta;
                        r_start <= r_req.timestamp;
                        if (r_active_idle) begin
                            r_idle <= r_idle + r_delta;
                        end else begin
                            r_busy <= r_busy + r_delta;
                        end
                    end
                    if (r_req.req_type == REQ_SWITCH_OUT) begin
                        r_active_valid <= 1'b0;
                        r_switches     <= r_switches + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_req_acc) begin
            r_req <= i_req;
        end
        // stamp before the start point charges nothing
        if (r_state == ST_CHARGE) begin
            r_delta     <= r_req.timestamp - r_start;
            r_do_charge <= r_active_valid && (r_req.timestamp >= r_start);
        end
        if ((r_state == ST_IWAIT) && w_sh_done) begin
            r_idle_ppm <= w_sh_ppm;
        end
        // share unit clears its quotient once idle, so hold the busy share here
        if ((r_state == ST_BWAIT) && w_sh_done) begin
            r_busy_ppm <= w_sh_ppm;
        end
        if ((r_state == ST_OUT) && w_out_free) begin
            r_rsp.wall_count   <= r_wall;
            r_rsp.idle_count   <= r_idle;
            r_rsp.busy_cycles  <= r_busy;
            r_rsp.switch_count <= r_switches;
            r_rsp.idle_ppm     <= r_idle_ppm;
            r_rsp.busy_ppm     <= r_busy_ppm;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule
